>>> rtl/core/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared constants, types and state codes of the k-way stream merger.
// ----------------------------------------------------------------------------
package kwm_pkg;

   localparam int MAX_LANES_DEF = 16;
   localparam int LANE_W        = 4;
   localparam int LANE_LIMIT    = 16;
   localparam int VALUE_W       = 32;
   localparam int CNT_W         = 5;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SCAN
   } kwm_state_type;

   typedef struct packed {
      logic clear;
      logic rd_en;
   } kwm_scan_ctl_type;

   typedef struct packed {
      logic pend;
      logic found;
   } kwm_scan_sts_type;

endpackage

>>> rtl/core/kwm_head_scan.sv
// ----------------------------------------------------------------------------
// kwm_head_scan
// Head value memory with a registered read and the running minimum search.
// ----------------------------------------------------------------------------
module kwm_head_scan
   import kwm_pkg::*;
#(
   parameter int LANE_CAP = LANE_LIMIT,
   parameter int IDX_W    = $clog2(LANE_CAP)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [IDX_W-1:0]       wr_addr,
   input  logic [VALUE_W-1:0]     wr_data,
   input  logic [IDX_W-1:0]       rd_addr,
   input  logic [LANE_CAP-1:0]    live,
   input  kwm_scan_ctl_type       ctl,
   output kwm_scan_sts_type       sts,
   output logic [VALUE_W-1:0]     best_value,
   output logic [IDX_W-1:0]       best_idx
);

   logic [VALUE_W-1:0] mem [LANE_CAP];
   logic [VALUE_W-1:0] rd_data_ff;
   logic               pend_ff;
   logic               pend_in;
   logic [IDX_W-1:0]   pend_idx_ff;
   logic               found_ff;
   logic               found_in;
   logic [VALUE_W-1:0] best_value_ff;
   logic [IDX_W-1:0]   best_idx_ff;
   logic               take;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         pend_idx_ff <= rd_addr;
      end
   end

   assign take = pend_ff && live[pend_idx_ff] &&
                 (!found_ff || ($signed(rd_data_ff) < $signed(best_value_ff)));

   always_comb begin
      pend_in  = ctl.rd_en;
      found_in = found_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && !ctl.clear) begin
         best_value_ff <= rd_data_ff;
         best_idx_ff   <= pend_idx_ff;
      end
   end

   assign sts.pend   = pend_ff;
   assign sts.found  = found_ff;
   assign best_value = best_value_ff;
   assign best_idx   = best_idx_ff;

   a_clear_drops_found: assert property (@(posedge clock) disable iff (reset)
      ctl.clear |=> !found_ff)
      else $error("search result survived a clear");

   a_found_stays: assert property (@(posedge clock) disable iff (reset)
      (found_ff && !ctl.clear) |=> found_ff)
      else $error("search result lost without a clear");

   a_pend_follows_read: assert property (@(posedge clock) disable iff (reset)
      ctl.rd_en |=> pend_ff)
      else $error("memory read not followed by a compare");

endmodule

>>> rtl/core/k_way_stream_merger.sv
// ----------------------------------------------------------------------------
// k_way_stream_merger
// Merges up to min(MAX_LANES, LANE_LIMIT) ascending signed streams into one stream.
//
// Channel  Dir  Handshake             Payload
// req      in   req_tvalid/tready     tdata: value; tuser: lane, lane_empty
// rsp      out  rsp_tvalid/tready     tdata: out_value; tuser: refill_lane, merge_done
// csr      in   csr_valid/csr_ready   csr_data: lanes_in_use
//
// A priming transaction or one for a lane outside the lane count leaves the merger idle.
// A transaction that starts a search reads the head memory one entry per cycle,
// n entries in all, n being the effective lane count.
// Reset clears the live bits, the priming count and the output valid flag.
// A search holds its result until the output register is free to take it.
// ----------------------------------------------------------------------------
module k_way_stream_merger
   import kwm_pkg::*;
#(
   parameter int MAX_LANES = MAX_LANES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [VALUE_W-1:0] req_tdata,   // [31:0] value
   input  logic [4:0]         req_tuser,   // [3:0] lane, [4] lane_empty
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [VALUE_W-1:0] rsp_tdata,   // [31:0] out_value
   output logic [4:0]         rsp_tuser,   // [3:0] refill_lane, [4] merge_done
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CNT_W-1:0]   csr_data
);

   localparam int LANE_CAP = (MAX_LANES < LANE_LIMIT) ? MAX_LANES : LANE_LIMIT;
   localparam int IDX_W    = $clog2(LANE_CAP);
   localparam logic [CNT_W-1:0] CAP_N = CNT_W'(LANE_CAP);

   kwm_state_type      state_ff, state_in;
   logic [CNT_W-1:0]   eff_n_ff, eff_n_in;
   logic [CNT_W-1:0]   primed_ff, primed_in;
   logic [CNT_W-1:0]   scan_cnt_ff, scan_cnt_in;
   logic [LANE_CAP-1:0] live_ff, live_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [LANE_W-1:0]  rsp_lane_ff, rsp_lane_in;
   logic               rsp_done_ff, rsp_done_in;

   logic               req_acc;
   logic               csr_acc;
   logic [LANE_W-1:0]  req_lane;
   logic               req_empty;
   logic               in_range;
   logic               wr_en;
   logic               scan_end;
   logic               out_free;
   logic               rsp_load;
   kwm_scan_ctl_type   scan_ctl;
   kwm_scan_sts_type   scan_sts;
   logic [VALUE_W-1:0] best_value;
   logic [IDX_W-1:0]   best_idx;

   assign req_lane  = req_tuser[LANE_W-1:0];
   assign req_empty = req_tuser[LANE_W];
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_tready = (state_ff == ST_IDLE) && !csr_valid;
   assign req_acc   = req_tvalid && req_tready;
   assign csr_acc   = csr_valid && csr_ready;
   assign in_range  = {1'b0, req_lane} < eff_n_ff;
   assign wr_en     = req_acc && in_range && !req_empty;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign scan_end  = (state_ff == ST_SCAN) && (scan_cnt_ff == eff_n_ff) && !scan_sts.pend;
   assign rsp_load  = scan_end && out_free;

   kwm_head_scan #(
      .LANE_CAP (LANE_CAP),
      .IDX_W    (IDX_W)
   ) u_head_scan (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_addr    (req_lane[IDX_W-1:0]),
      .wr_data    (req_tdata),
      .rd_addr    (scan_cnt_ff[IDX_W-1:0]),
      .live       (live_ff),
      .ctl        (scan_ctl),
      .sts        (scan_sts),
      .best_value (best_value),
      .best_idx   (best_idx)
   );

   always_comb begin
      state_in       = state_ff;
      eff_n_in       = eff_n_ff;
      primed_in      = primed_ff;
      scan_cnt_in    = scan_cnt_ff;
      live_in        = live_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_value_in   = rsp_value_ff;
      rsp_lane_in    = rsp_lane_ff;
      rsp_done_in    = rsp_done_ff;
      scan_ctl.clear = 1'b0;
      scan_ctl.rd_en = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (csr_acc) begin
               if (csr_data == '0) begin
                  eff_n_in = CNT_W'(1);
               end else if (csr_data > CAP_N) begin
                  eff_n_in = CAP_N;
               end else begin
                  eff_n_in = csr_data;
               end
               primed_in = '0;
               live_in   = '0;
            end else if (req_acc && in_range) begin
               live_in[req_lane[IDX_W-1:0]] = !req_empty;
               if (primed_ff < eff_n_ff) begin
                  primed_in = primed_ff + CNT_W'(1);
               end
               if ((primed_ff >= eff_n_ff) || (primed_ff + CNT_W'(1) == eff_n_ff)) begin
                  state_in       = ST_SCAN;
                  scan_cnt_in    = '0;
                  scan_ctl.clear = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (scan_cnt_ff < eff_n_ff) begin
               scan_ctl.rd_en = 1'b1;
               scan_cnt_in    = scan_cnt_ff + CNT_W'(1);
            end
            if (rsp_load) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (scan_sts.found) begin
                  rsp_value_in = best_value;
                  rsp_lane_in  = LANE_W'(best_idx);
                  rsp_done_in  = 1'b0;
               end else begin
                  rsp_value_in = '0;
                  rsp_lane_in  = '0;
                  rsp_done_in  = 1'b1;
                  live_in      = '0;
                  primed_in    = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         eff_n_ff     <= CAP_N;
         primed_ff    <= '0;
         scan_cnt_ff  <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         eff_n_ff     <= eff_n_in;
         primed_ff    <= primed_in;
         scan_cnt_ff  <= scan_cnt_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_lane_ff  <= rsp_lane_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = {rsp_done_ff, rsp_lane_ff};

   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && !scan_sts.found) |=> (live_ff == '0) && (primed_ff == '0))
      else $error("merge finished but live lanes or priming count remain");

   a_primed_bound: assert property (@(posedge clock) disable iff (reset)
      primed_ff <= eff_n_ff)
      else $error("priming count exceeds lane count");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_cnt_ff <= eff_n_ff))
      else $error("scan index ran past the lane count");

   a_result_from_scan: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_SCAN))
      else $error("result appeared without a finished scan");

endmodule
